[hdl/pee_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// postfix evaluator package
// shared widths, character codes, symbol decode, fsm states and the
// command / status bundles between controller and datapath
// ---------------------------------------------------------------------------
package pee_pkg;

   localparam int WORD_W      = 32;
   localparam int SYM_W       = 8;
   localparam int STACK_DEPTH = 64;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = $clog2(STACK_DEPTH);
   localparam int DIV_CNT_W   = $clog2(WORD_W);
   localparam int FLAG_W      = 3;

   // ascii codes
   localparam logic [SYM_W-1:0] CH_ZERO   = 8'h30;
   localparam logic [SYM_W-1:0] CH_PLUS   = 8'h2B;
   localparam logic [SYM_W-1:0] CH_MINUS  = 8'h2D;
   localparam logic [SYM_W-1:0] CH_STAR   = 8'h2A;
   localparam logic [SYM_W-1:0] CH_SLASH  = 8'h2F;
   localparam logic [SYM_W-1:0] CH_LPAREN = 8'h28;
   localparam logic [SYM_W-1:0] CH_RPAREN = 8'h29;

   // sticky flag positions
   localparam int FLAG_UNDER = 0;
   localparam int FLAG_OVER  = 1;
   localparam int FLAG_DIVZ  = 2;

   typedef enum logic [2:0] {
      CLS_OPERAND,
      CLS_ADD,
      CLS_SUB,
      CLS_MUL,
      CLS_DIV,
      CLS_PAREN
   } sym_class_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP_LHS,
      ST_EXEC,
      ST_DIV_WAIT,
      ST_PUSH,
      ST_FINISH,
      ST_ANSWER
   } state_type;

   typedef struct packed {
      logic load_item;
      logic push_sym;
      logic pop;
      logic cap_rhs;
      logic exec;
      logic div_load;
      logic push_res;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic          in_operand;
      logic          in_last;
      sym_class_type cls;
      logic          last;
      logic          rhs_zero;
      logic          div_done;
      logic          rsp_free;
   } status_type;

   function automatic sym_class_type decode_symbol(input logic [SYM_W-1:0] sym);
      sym_class_type cls;
      case (sym)
         CH_PLUS:   cls = CLS_ADD;
         CH_MINUS:  cls = CLS_SUB;
         CH_STAR:   cls = CLS_MUL;
         CH_SLASH:  cls = CLS_DIV;
         CH_LPAREN: cls = CLS_PAREN;
         CH_RPAREN: cls = CLS_PAREN;
         default:   cls = CLS_OPERAND;
      endcase
      return cls;
   endfunction

endpackage

[hdl/pee_req_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// request channel
// one expression character per word
// ---------------------------------------------------------------------------
interface pee_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       last_symbol;

   modport source (output valid, output symbol, output last_symbol, input ready);
   modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

[hdl/pee_rsp_if.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// response channel
// evaluated answer and sticky error flags
// ---------------------------------------------------------------------------
interface pee_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic               underflow;
   logic               overflow;
   logic               divide_by_zero;

   modport source (output valid, output value, output underflow, output overflow,
                   output divide_by_zero, input ready);
   modport sink   (input valid, input value, input underflow, input overflow,
                   input divide_by_zero, output ready);
endinterface

[hdl/pee_div.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// iterative signed divider
// restoring radix-2 on magnitudes, one quotient bit per cycle, truncating
// ---------------------------------------------------------------------------
module pee_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [pee_pkg::WORD_W-1:0]  dividend,
   input  logic [pee_pkg::WORD_W-1:0]  divisor,
   output logic                        done,
   output logic [pee_pkg::WORD_W-1:0]  quotient
);
   import pee_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0]    rem_ff, rem_in;
   logic [WORD_W-1:0]    quo_ff, quo_in;
   logic [WORD_W-1:0]    dvs_ff, dvs_in;
   logic                 neg_ff, neg_in;
   logic [WORD_W:0]      shifted;
   logic [WORD_W:0]      trial;

   assign shifted = {rem_ff, quo_ff[WORD_W-1]};
   assign trial   = shifted - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         quo_in  = dividend[WORD_W-1] ? (WORD_W'(0) - dividend) : dividend;
         dvs_in  = divisor[WORD_W-1] ? (WORD_W'(0) - divisor) : divisor;
         neg_in  = dividend[WORD_W-1] ^ divisor[WORD_W-1];
      end else if (busy_ff) begin
         if (trial[WORD_W]) begin
            rem_in = shifted[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b0};
         end else begin
            rem_in = trial[WORD_W-1:0];
            quo_in = {quo_ff[WORD_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(WORD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? (WORD_W'(0) - quo_ff) : quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

endmodule

[hdl/pee_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// evaluator controller
// sequences pops, arithmetic, pushes and the answer pop per word
// ---------------------------------------------------------------------------
module pee_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pee_pkg::status_type  status,
   output pee_pkg::cmd_type     cmd
);
   import pee_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (!status.in_operand)   state_in = ST_POP_LHS;
               else if (status.in_last)  state_in = ST_FINISH;
               else                      state_in = ST_IDLE;
            end
         end
         ST_POP_LHS: state_in = ST_EXEC;
         ST_EXEC: begin
            case (status.cls)
               CLS_ADD:   state_in = ST_PUSH;
               CLS_SUB:   state_in = ST_PUSH;
               CLS_MUL:   state_in = ST_PUSH;
               CLS_DIV:   state_in = status.rhs_zero ? ST_PUSH : ST_DIV_WAIT;
               CLS_PAREN: state_in = status.last ? ST_FINISH : ST_IDLE;
               default:   state_in = ST_IDLE;
            endcase
         end
         ST_DIV_WAIT: begin
            if (status.div_done) state_in = ST_PUSH;
         end
         ST_PUSH:   state_in = status.last ? ST_FINISH : ST_IDLE;
         ST_FINISH: state_in = ST_ANSWER;
         ST_ANSWER: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               cmd.push_sym  = status.in_operand;
               cmd.pop       = !status.in_operand;
            end
         end
         ST_POP_LHS: begin
            cmd.cap_rhs = 1'b1;
            cmd.pop     = 1'b1;
         end
         ST_EXEC:     cmd.exec     = 1'b1;
         ST_DIV_WAIT: cmd.div_load = status.div_done;
         ST_PUSH:     cmd.push_res = 1'b1;
         ST_FINISH:   cmd.pop      = 1'b1;
         ST_ANSWER:   cmd.emit     = status.rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

endmodule

[hdl/pee_dpath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// evaluator datapath
// value stack memory, count, operand registers, alu, flags, output register
// ---------------------------------------------------------------------------
module pee_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  pee_pkg::cmd_type                  cmd,
   output pee_pkg::status_type               status,
   input  logic [pee_pkg::SYM_W-1:0]         symbol,
   input  logic                              last_symbol,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [pee_pkg::WORD_W-1:0] rsp_value,
   output logic                              rsp_underflow,
   output logic                              rsp_overflow,
   output logic                              rsp_divide_by_zero
);
   import pee_pkg::*;

   logic [WORD_W-1:0] stack_ff [STACK_DEPTH];
   logic [WORD_W-1:0] rd_data_ff;
   logic              rd_ok_ff, rd_ok_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  count_dec;
   logic [FLAG_W-1:0] flags_ff, flags_in;
   sym_class_type     cls_ff, cls_in;
   logic              last_ff, last_in;
   logic [WORD_W-1:0] rhs_ff;
   logic [WORD_W-1:0] result_ff, result_in;
   logic [WORD_W-1:0] popped;
   logic [WORD_W-1:0] sym_value;
   logic [WORD_W-1:0] wr_data;
   logic              wr_en;
   logic              rd_en;
   logic              stack_full;
   logic              stack_empty;
   logic              div_start;
   logic              div_done;
   logic [WORD_W-1:0] div_quotient;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0] rsp_value_ff;
   logic [FLAG_W-1:0] rsp_flags_ff;

   assign stack_full  = (count_ff == CNT_W'(STACK_DEPTH));
   assign stack_empty = (count_ff == '0);
   assign count_dec   = count_ff - CNT_W'(1);
   assign popped      = rd_ok_ff ? rd_data_ff : '1;
   assign sym_value   = WORD_W'(symbol) - WORD_W'(CH_ZERO);

   // push / pop
   always_comb begin
      wr_data  = cmd.push_sym ? sym_value : result_ff;
      wr_en    = (cmd.push_sym || cmd.push_res) && !stack_full;
      rd_en    = cmd.pop && !stack_empty;
      rd_ok_in = cmd.pop ? !stack_empty : rd_ok_ff;
      count_in = count_ff;
      flags_in = flags_ff;
      if (wr_en) count_in = count_ff + CNT_W'(1);
      if (rd_en) count_in = count_dec;
      if ((cmd.push_sym || cmd.push_res) && stack_full) flags_in[FLAG_OVER] = 1'b1;
      if (cmd.pop && stack_empty) flags_in[FLAG_UNDER] = 1'b1;
      if (cmd.exec && cls_ff == CLS_DIV && rhs_ff == '0) flags_in[FLAG_DIVZ] = 1'b1;
      if (cmd.emit) flags_in = '0;
   end

   always_ff @(posedge clock) begin
      if (wr_en) stack_ff[count_ff[ADDR_W-1:0]] <= wr_data;
      if (rd_en) rd_data_ff <= stack_ff[count_dec[ADDR_W-1:0]];
   end

   // item latch and arithmetic
   assign cls_in  = cmd.load_item ? decode_symbol(symbol) : cls_ff;
   assign last_in = cmd.load_item ? last_symbol : last_ff;

   always_comb begin
      result_in = result_ff;
      if (cmd.exec) begin
         case (cls_ff)
            CLS_ADD: result_in = popped + rhs_ff;
            CLS_SUB: result_in = popped - rhs_ff;
            CLS_MUL: result_in = popped * rhs_ff;
            default: result_in = '0;
         endcase
      end else if (cmd.div_load) begin
         result_in = div_quotient;
      end
   end

   assign div_start = cmd.exec && (cls_ff == CLS_DIV) && (rhs_ff != '0);

   pee_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (popped),
      .divisor  (rhs_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit)      rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         flags_ff     <= '0;
         rd_ok_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         flags_ff     <= flags_in;
         rd_ok_ff     <= rd_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cls_ff    <= cls_in;
      last_ff   <= last_in;
      result_ff <= result_in;
      if (cmd.cap_rhs) rhs_ff <= popped;
      if (cmd.emit) begin
         rsp_value_ff <= popped;
         rsp_flags_ff <= flags_ff;
      end
   end

   assign status.in_operand = (decode_symbol(symbol) == CLS_OPERAND);
   assign status.in_last    = last_symbol;
   assign status.cls        = cls_ff;
   assign status.last       = last_ff;
   assign status.rhs_zero   = (rhs_ff == '0);
   assign status.div_done   = div_done;
   assign status.rsp_free   = !rsp_valid_ff || rsp_ready;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_value          = rsp_value_ff;
   assign rsp_underflow      = rsp_flags_ff[FLAG_UNDER];
   assign rsp_overflow       = rsp_flags_ff[FLAG_OVER];
   assign rsp_divide_by_zero = rsp_flags_ff[FLAG_DIVZ];

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count beyond depth");

   a_emit_clears_flags: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (flags_ff == '0) && rsp_valid_ff)
      else $error("flags not cleared or word not loaded after answer");

   a_one_stack_op: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.push_sym, cmd.push_res, cmd.pop, cmd.emit}))
      else $error("conflicting stack commands");

endmodule

[hdl/postfix_expression_evaluator_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// postfix expression evaluator
// evaluates a postfix expression streamed one ascii character per word on a
// bounded stack of signed 32-bit values, answering on the last character
// ---------------------------------------------------------------------------
//
//  channel   dir  handshake          payload
//  req_if    in   valid / ready      symbol[7:0], last_symbol
//  rsp_if    out  valid / ready      value[31:0] signed, underflow, overflow,
//                                    divide_by_zero
//
//  steps: operand push; + - * pop both, execute, push; parenthesis pops
//  both and pushes nothing; divide waits on the one-bit-per-cycle divider
//  unless the divisor is zero; a last character adds the answer pop
//  stack memory has one access per cycle, so each pop or push takes a step
//  reset: synchronous, active high; clears stack count, flags, fsm state and
//  the output valid; stack entries are never cleared
//  stalls: req_ready is high only while the sequencer is idle; a waiting
//  answer does not block new words, only the next answer load
//
module postfix_expression_evaluator_top (
   input logic      clock,
   input logic      reset,
   pee_req_if.sink   req_if,
   pee_rsp_if.source rsp_if
);
   import pee_pkg::*;

   cmd_type    cmd;
   status_type status;

   // controller: sequences one word at a time
   pee_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: stack, alu, divider, output register
   pee_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .symbol             (req_if.symbol),
      .last_symbol        (req_if.last_symbol),
      .rsp_valid          (rsp_if.valid),
      .rsp_ready          (rsp_if.ready),
      .rsp_value          (rsp_if.value),
      .rsp_underflow      (rsp_if.underflow),
      .rsp_overflow       (rsp_if.overflow),
      .rsp_divide_by_zero (rsp_if.divide_by_zero)
   );

endmodule
